// ----- rtl/core/rtkm_pkg.sv -----
// Package for the radix tree key map: sizes, opcodes, status codes and states.
package rtkm_pkg;

    localparam int KEY_BITS_DEF   = 32;
    localparam int DIGIT_BITS_DEF = 4;
    localparam int NODE_COUNT_DEF = 256;
    localparam int VALUE_BITS_DEF = 32;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_MISS   = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_WALK_RD,
        S_WALK_EV,
        S_DECIDE,
        S_INS_POP,
        S_INS_WR,
        S_INS_CLR,
        S_INS_LEAF,
        S_REM_SCAN,
        S_REM_EV,
        S_REM_UNLINK,
        S_RESULT
    } state_t;

endpackage

// ----- rtl/core/radix_tree_key_map.sv -----
// Radix tree key map: fixed-depth tree over a node RAM with a bounded free pool.
//
// Input channel s_*: tdata = {value, key, opcode}, one operation per item.
// Result channel m_*: tdata = {value_out, status}, one result per item.
// A small sequencer drives one node RAM port and one free-stack RAM port; every
// tree access is one RAM read or write, so each item is a sequence of steps on
// that single port:
//   search: the walk reads and checks one level at a time (S_WALK_RD, S_WALK_EV),
//     then S_DECIDE picks the status and S_RESULT presents it.
//   insert: walk, then a pop, a link write and a clear of its FAN slots per node
//     created, then the leaf write.
//   remove: walk, then a slot scan per level upward and an unlink of empty nodes.
// s_tready is high only in the idle state; the block holds one item at a time.
// The result sits in an output register until m_tready takes it; no new item
// is taken before that.
// After reset a fill pass loads the free stack and clears the root slots;
// s_tready stays low meanwhile.
module radix_tree_key_map
    import rtkm_pkg::*;
#(
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int DIGIT_BITS = DIGIT_BITS_DEF,
    parameter int NODE_COUNT = NODE_COUNT_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // opcode[1:0], key[33:2], value[65:34], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // status[1:0], value_out[33:2], zero pad
);

    localparam int FAN    = 1 << DIGIT_BITS;
    localparam int DEPTH  = (KEY_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int NB     = $clog2(NODE_COUNT);
    localparam int CB     = $clog2(NODE_COUNT + 1);
    localparam int AB     = NB + DIGIT_BITS;
    localparam int SW     = (VALUE_BITS > NB) ? VALUE_BITS : NB;
    localparam int LB     = $clog2(DEPTH + 1);
    localparam int KW     = DEPTH * DIGIT_BITS;
    localparam int PB     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int KIB    = (KEY_BITS < 32) ? KEY_BITS : 32;
    localparam int VIB    = (VALUE_BITS < 32) ? VALUE_BITS : 32;

    state_t state_reg, state_next;

    logic [1:0]            op_reg, op_next;
    logic [KW-1:0]         key_reg, key_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [NB-1:0]         path_reg [DEPTH];
    logic [NB-1:0]         path_next [DEPTH];
    logic [LB-1:0]         lvl_reg, lvl_next;
    logic [CB-1:0]         cnt_reg, cnt_next;
    logic [DIGIT_BITS:0]   j_reg, j_next;
    logic [NB-1:0]         newn_reg, newn_next;
    logic [1:0]            status_reg, status_next;
    logic [31:0]           vout_reg, vout_next;
    logic                  mval_reg, mval_next;

    logic          t_we;
    logic [AB-1:0] t_addr;
    logic [SW-1:0] t_wdata, t_rdata;
    logic          f_we;
    logic [NB-1:0] f_addr, f_wdata, f_rdata;

    rtkm_ram #(.WIDTH(SW), .DEPTH(NODE_COUNT * FAN)) u_tab (
        .aclk(aclk), .we(t_we), .addr(t_addr), .wdata(t_wdata), .rdata(t_rdata)
    );
    rtkm_ram #(.WIDTH(NB), .DEPTH(NODE_COUNT)) u_free (
        .aclk(aclk), .we(f_we), .addr(f_addr), .wdata(f_wdata), .rdata(f_rdata)
    );

    function automatic logic [DIGIT_BITS-1:0] digit_of(
        input logic [KW-1:0] k, input logic [LB-1:0] l);
        logic [KW-1:0] sh;
        sh = k >> ((DEPTH - 1 - int'(l)) * DIGIT_BITS);
        return sh[DIGIT_BITS-1:0];
    endfunction

    logic [KIB-1:0]      key_in;
    logic [KW-1:0]       key_ext;
    logic [LB-1:0]       last_lvl;
    logic [NB-1:0]       cur_node;
    logic [NB-1:0]       node_sel;
    logic [NB-1:0]       upper_node;
    logic [DIGIT_BITS-1:0] cur_dig;
    logic [DIGIT_BITS-1:0] upper_dig;
    logic [PB-1:0]       up_idx;
    logic [PB-1:0]       down_idx;

    assign key_in   = s_tdata[2 +: KIB];
    assign key_ext  = KW'(key_in);
    assign last_lvl = LB'(DEPTH - 1);
    assign cur_node = path_reg[lvl_reg[PB-1:0]];
    assign cur_dig  = digit_of(key_reg, lvl_reg);
    assign up_idx   = PB'(lvl_reg - LB'(1));
    assign down_idx = PB'(lvl_reg + LB'(1));
    assign node_sel = (lvl_reg == 0) ? NB'(0) : path_reg[up_idx];
    assign upper_node = node_sel;
    assign upper_dig  = digit_of(key_reg, lvl_reg - LB'(1));

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mval_reg;
    assign m_tdata  = {6'd0, vout_reg, status_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            cnt_reg   <= '0;
            mval_reg  <= 1'b0;
            j_reg     <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            mval_reg  <= mval_next;
            j_reg     <= j_next;
        end
        op_reg     <= op_next;
        key_reg    <= key_next;
        val_reg    <= val_next;
        lvl_reg    <= lvl_next;
        newn_reg   <= newn_next;
        status_reg <= status_next;
        vout_reg   <= vout_next;
        path_reg   <= path_next;
    end

    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        val_next    = val_reg;
        path_next   = path_reg;
        lvl_next    = lvl_reg;
        cnt_next    = cnt_reg;
        j_next      = j_reg;
        newn_next   = newn_reg;
        status_next = status_reg;
        vout_next   = vout_reg;
        mval_next   = mval_reg;
        t_we        = 1'b0;
        t_addr      = {cur_node, cur_dig};
        t_wdata     = '0;
        f_we        = 1'b0;
        f_addr      = NB'(cnt_reg - CB'(1));
        f_wdata     = '0;

        unique case (state_reg)
            S_INIT: begin
                // Fill stack slot i with i+1; clear root slots alongside.
                f_we    = 1'b1;
                f_addr  = NB'(cnt_reg);
                f_wdata = NB'(cnt_reg + CB'(1));
                t_we    = (j_reg < (DIGIT_BITS + 1)'(FAN));
                t_addr  = AB'(j_reg[DIGIT_BITS-1:0]);
                if (j_reg < (DIGIT_BITS + 1)'(FAN)) begin
                    j_next = j_reg + 1'b1;
                end
                if (cnt_reg != CB'(NODE_COUNT - 1)) begin
                    cnt_next = cnt_reg + CB'(1);
                end
                if (cnt_reg == CB'(NODE_COUNT - 1) &&
                    j_reg >= (DIGIT_BITS + 1)'(FAN - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next   = s_tdata[1:0];
                    key_next  = key_ext;
                    val_next  = VALUE_BITS'(s_tdata[34 +: VIB]);
                    lvl_next  = '0;
                    path_next[0] = '0;
                    vout_next = '0;
                    status_next = ST_OK;
                    state_next = S_WALK_RD;
                end
            end
            S_WALK_RD: begin
                state_next = S_WALK_EV;
            end
            S_WALK_EV: begin
                // Descend while the inner slot holds a child.
                if (lvl_reg == last_lvl) begin
                    state_next = S_DECIDE;
                end else if (t_rdata == '0) begin
                    state_next = S_DECIDE;
                end else begin
                    path_next[down_idx] = NB'(t_rdata);
                    lvl_next   = lvl_reg + LB'(1);
                    state_next = S_WALK_RD;
                end
            end
            S_DECIDE: begin
                // t_rdata still holds the slot read at lvl_reg.
                state_next = S_RESULT;
                if (op_reg == OP_INSERT) begin
                    if (lvl_reg == last_lvl && t_rdata != '0) begin
                        status_next = ST_MISS;
                    end else if (val_reg == '0) begin
                        status_next = ST_OK;
                    end else if (CB'(last_lvl - lvl_reg) > cnt_reg) begin
                        status_next = ST_FULL;
                    end else if (lvl_reg == last_lvl) begin
                        state_next = S_INS_LEAF;
                    end else begin
                        state_next = S_INS_POP;
                    end
                end else if (op_reg == OP_SEARCH || op_reg == OP_REMOVE) begin
                    if (lvl_reg != last_lvl || t_rdata == '0) begin
                        status_next = ST_MISS;
                    end else begin
                        vout_next = 32'(t_rdata[VALUE_BITS-1:0]);
                        if (op_reg == OP_REMOVE) begin
                            t_we    = 1'b1;
                            j_next  = '0;
                            if (DEPTH > 1) begin
                                state_next = S_REM_SCAN;
                            end
                        end
                    end
                end
            end
            S_INS_POP: begin
                f_addr     = NB'(cnt_reg - CB'(1));
                cnt_next   = cnt_reg - CB'(1);
                state_next = S_INS_WR;
            end
            S_INS_WR: begin
                newn_next  = f_rdata;
                t_we       = 1'b1;
                t_wdata    = SW'(f_rdata);
                j_next     = '0;
                state_next = S_INS_CLR;
            end
            S_INS_CLR: begin
                t_we   = 1'b1;
                t_addr = {newn_reg, j_reg[DIGIT_BITS-1:0]};
                if (j_reg == (DIGIT_BITS + 1)'(FAN - 1)) begin
                    path_next[down_idx] = newn_reg;
                    lvl_next = lvl_reg + LB'(1);
                    state_next = (lvl_reg + LB'(1) == last_lvl) ? S_INS_LEAF : S_INS_POP;
                end
                j_next = j_reg + 1'b1;
            end
            S_INS_LEAF: begin
                t_we       = 1'b1;
                t_wdata    = SW'(val_reg);
                state_next = S_RESULT;
            end
            S_REM_SCAN: begin
                // Read each slot of the node at lvl_reg; stop at the first nonzero one.
                t_addr = {cur_node, j_reg[DIGIT_BITS-1:0]};
                state_next = S_REM_EV;
            end
            S_REM_EV: begin
                t_addr = {cur_node, j_reg[DIGIT_BITS-1:0]};
                if (t_rdata != '0) begin
                    state_next = S_RESULT;
                end else if (j_reg == (DIGIT_BITS + 1)'(FAN - 1)) begin
                    state_next = S_REM_UNLINK;
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_REM_SCAN;
                end
            end
            S_REM_UNLINK: begin
                // Give the empty node back and clear its parent slot.
                if (cnt_reg < CB'(NODE_COUNT)) begin
                    f_we     = 1'b1;
                    f_addr   = NB'(cnt_reg);
                    f_wdata  = cur_node;
                    cnt_next = cnt_reg + CB'(1);
                end
                t_we     = 1'b1;
                t_addr   = {upper_node, upper_dig};
                lvl_next = lvl_reg - LB'(1);
                j_next   = '0;
                state_next = (lvl_reg == LB'(1)) ? S_RESULT : S_REM_SCAN;
            end
            S_RESULT: begin
                mval_next = 1'b1;
                if (mval_reg && m_tready) begin
                    mval_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CB'(NODE_COUNT))
        else $error("free count overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !m_tvalid)
        else $error("result before work");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result dropped while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input taken while result pending");

endmodule

// ----- rtl/core/rtkm_ram.sv -----
// Generic single-port RAM with registered read.
module rtkm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- test/tb_radix_tree_key_map.sv -----
// Testbench for the radix tree key map: directed table plus random traffic, scoreboarded.
module tb_radix_tree_key_map;
    import rtkm_pkg::*;

    localparam int FAN   = 16;
    localparam int LEVELS = 8;
    localparam int NODES = 256;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;   // opcode[1:0], key[33:2], value[65:34], zero pad
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // status[1:0], value_out[33:2], zero pad

    radix_tree_key_map dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] value_out;
    } reply_t;

    typedef struct {
        logic [1:0]  opcode;
        logic [31:0] key;
        logic [31:0] value;
        bit          typed;   // expected reply typed in the table
        reply_t      reply;
    } row_t;

    // shadow of the tree
    logic [31:0] slot_mem [NODES*FAN];
    int          free_stack [NODES];
    int          free_cnt;
    reply_t      pending_replies [$];
    logic [31:0] used_keys [$];
    int          errors;
    bit          quiet;    // sender idling switched off
    bit          sink_quiet;

    function automatic int digit_of(logic [31:0] key, int lvl);
        return int'((key >> ((LEVELS - 1 - lvl) * 4)) & 4'hF);
    endfunction

    function automatic void tree_reset();
        for (int i = 0; i < NODES*FAN; i++) slot_mem[i] = '0;
        for (int i = 0; i < NODES - 1; i++) free_stack[i] = i + 1;
        free_cnt = NODES - 1;
    endfunction

    function automatic bit node_is_empty(int n);
        for (int j = 0; j < FAN; j++)
            if (slot_mem[n*FAN + j] != 0) return 0;
        return 1;
    endfunction

    function automatic reply_t tree_apply(logic [1:0] op, logic [31:0] key,
                                          logic [31:0] val);
        int     path [LEVELS];
        int     reached;
        int     n;
        int     leaf;
        reply_t r;
        r = '0;
        path[0] = 0;
        reached = LEVELS - 1;
        for (int l = 0; l < LEVELS - 1; l++) begin
            logic [31:0] c;
            c = slot_mem[path[l]*FAN + digit_of(key, l)];
            if (c == 0) begin
                reached = l;
                break;
            end
            path[l+1] = int'(c % NODES);
        end
        if (op == OP_INSERT) begin
            if (reached == LEVELS - 1 &&
                slot_mem[path[LEVELS-1]*FAN + digit_of(key, LEVELS-1)] != 0)
                r.status = ST_MISS;
            else if (val == 0)
                r.status = ST_OK;
            else if (LEVELS - 1 - reached > free_cnt)
                r.status = ST_FULL;
            else begin
                for (int l = reached; l < LEVELS - 1; l++) begin
                    free_cnt--;
                    n = free_stack[free_cnt] % NODES;
                    for (int j = 0; j < FAN; j++) slot_mem[n*FAN + j] = '0;
                    slot_mem[path[l]*FAN + digit_of(key, l)] = n;
                    path[l+1] = n;
                end
                slot_mem[path[LEVELS-1]*FAN + digit_of(key, LEVELS-1)] = val;
            end
        end else if (op == OP_SEARCH || op == OP_REMOVE) begin
            if (reached != LEVELS - 1) r.status = ST_MISS;
            else begin
                leaf = path[LEVELS-1]*FAN + digit_of(key, LEVELS-1);
                if (slot_mem[leaf] == 0) r.status = ST_MISS;
                else begin
                    r.value_out = slot_mem[leaf];
                    if (op == OP_REMOVE) begin
                        slot_mem[leaf] = '0;
                        // give back nodes that went empty, walking up
                        for (int l = LEVELS - 1; l != 0; l--) begin
                            if (!node_is_empty(path[l])) break;
                            if (free_cnt < NODES) begin
                                free_stack[free_cnt] = path[l];
                                free_cnt++;
                            end
                            slot_mem[path[l-1]*FAN + digit_of(key, l-1)] = '0;
                        end
                    end
                end
            end
        end
        return r;
    endfunction

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    task automatic send_item(logic [1:0] op, logic [31:0] key, logic [31:0] val,
                             bit typed, reply_t want);
        reply_t pred;
        while (!quiet && $urandom_range(99) < 27) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, val, key, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pred = tree_apply(op, key, val);
        if (typed && pred != want) begin
            $error("table row disagrees with prediction: want %h got %h", want, pred);
            errors++;
        end
        pending_replies.push_back(typed ? want : pred);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge aclk);
    endtask

    // result side: random stall, compare at the handshake edge
    always @(posedge aclk) begin
        reply_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_replies.size() == 0) begin
                $error("unexpected result %h", m_tdata);
                errors++;
            end else begin
                exp_r = pending_replies.pop_front();
                if (m_tdata[1:0] != exp_r.status) begin
                    $error("status expected %0d actual %0d", exp_r.status, m_tdata[1:0]);
                    errors++;
                end
                if (m_tdata[33:2] != exp_r.value_out) begin
                    $error("value_out expected %h actual %h", exp_r.value_out,
                           m_tdata[33:2]);
                    errors++;
                end
            end
        end
        m_tready <= sink_quiet ? 1'b1 : ($urandom_range(99) >= 27);
    end

    function automatic logic [31:0] pick_key();
        if (used_keys.size() != 0 && $urandom_range(99) < 60)
            return used_keys[$urandom_range(used_keys.size() - 1)];
        // mostly clustered keys so paths share inner nodes
        if ($urandom_range(99) < 70)
            return {20'h5A3C9, 8'h00, 4'($urandom_range(15))} ^ ($urandom_range(255) << 4);
        return $urandom();
    endfunction

    row_t plan [$];

    function automatic row_t mk(logic [1:0] op, logic [31:0] k, logic [31:0] v,
                                bit typed, logic [1:0] st, logic [31:0] vo);
        row_t r;
        r.opcode = op; r.key = k; r.value = v; r.typed = typed;
        r.reply.status = st; r.reply.value_out = vo;
        return r;
    endfunction

    initial begin
        logic [1:0]  op;
        logic [31:0] k;
        logic [31:0] v;
        int          r;
        logic [31:0] pool_keys [$];
        errors = 0; quiet = 0; sink_quiet = 0;
        aresetn = 1'b0; s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
        tree_reset();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        plan.push_back(mk(OP_SEARCH, 32'h0,        32'h0,        1, ST_MISS, 0));
        plan.push_back(mk(OP_REMOVE, 32'hFFFFFFFF, 32'h0,        1, ST_MISS, 0));
        plan.push_back(mk(OP_INSERT, 32'h0,        32'h0,        1, ST_OK,   0));
        plan.push_back(mk(OP_INSERT, 32'h0,        32'hFFFFFFFF, 1, ST_OK,   0));
        plan.push_back(mk(OP_SEARCH, 32'h0,        32'h0,        1, ST_OK,   32'hFFFFFFFF));
        plan.push_back(mk(OP_INSERT, 32'h0,        32'h1,        1, ST_MISS, 0));
        plan.push_back(mk(OP_INSERT, 32'h0,        32'h0,        1, ST_MISS, 0));
        plan.push_back(mk(OP_INSERT, 32'hFFFFFFFF, 32'h1,        1, ST_OK,   0));
        plan.push_back(mk(OP_INSERT, 32'hFFFFFFFE, 32'h80000000, 0, 0, 0));
        plan.push_back(mk(OP_SEARCH, 32'hFFFFFFFE, 32'h0,        0, 0, 0));
        plan.push_back(mk(OP_NONE,   32'hFFFFFFFF, 32'h12345678, 1, ST_OK,   0));
        plan.push_back(mk(OP_REMOVE, 32'hFFFFFFFF, 32'h0,        1, ST_OK,   32'h1));
        plan.push_back(mk(OP_SEARCH, 32'hFFFFFFFF, 32'h0,        1, ST_MISS, 0));
        plan.push_back(mk(OP_REMOVE, 32'hFFFFFFFE, 32'h0,        0, 0, 0));
        plan.push_back(mk(OP_REMOVE, 32'h0,        32'h0,        1, ST_OK,   32'hFFFFFFFF));
        plan.push_back(mk(OP_INSERT, 32'h0F0F0F0F, 32'hA5A5A5A5, 0, 0, 0));
        plan.push_back(mk(OP_SEARCH, 32'h0F0F0F0E, 32'h0,        0, 0, 0));
        plan.push_back(mk(OP_REMOVE, 32'h0F0F0F0F, 32'h0,        0, 0, 0));
        foreach (plan[i])
            send_item(plan[i].opcode, plan[i].key, plan[i].value, plan[i].typed,
                      plan[i].reply);
        drain();

        // exhaust the pool: distinct top digit pairs force six or seven new nodes each
        for (int i = 0; i < 40; i++) begin
            k = {4'(i), 4'(i >> 4), 8'($urandom_range(255)), 16'($urandom_range(65535))};
            pool_keys.push_back(k);
            send_item(OP_INSERT, k, $urandom() | 1, 0, '0);
        end
        send_item(OP_INSERT, 32'h8F000000, 32'h77, 0, '0);
        foreach (pool_keys[i])
            send_item(OP_REMOVE, pool_keys[i], 0, 0, '0);
        drain();

        for (int i = 0; i < 840; i++) begin
            quiet      = (i >= 300 && i < 420);
            sink_quiet = (i >= 300 && i < 420);
            r = $urandom_range(99);
            op = r < 45 ? OP_INSERT : r < 70 ? OP_SEARCH : r < 97 ? OP_REMOVE : OP_NONE;
            k = pick_key();
            v = ($urandom_range(19) == 0) ? 32'h0 : $urandom();
            if (op == OP_INSERT && used_keys.size() < 64) used_keys.push_back(k);
            send_item(op, k, v, 0, '0);
            if (i == 600) drain();
        end
        drain();
        repeat (200) @(posedge aclk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #20000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
